// ===== hdl/tkt_pkg.sv =====
package tkt_pkg;

    // Field widths fixed by the item formats.
    localparam int FUNC_W  = 2;
    localparam int TAG_W   = 32;
    localparam int CAND_W  = 32;
    localparam int VALUE_W = 31;
    localparam int RANK_W  = 7;

    // Default number of table slots.
    localparam int DEF_ENTRIES = 36;

    // Function codes carried in the input item.
    localparam logic [FUNC_W-1:0] FUNC_OFFER  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [TAG_W-1:0]         candidate_tag;
        logic signed [CAND_W-1:0] candidate_value;
    } t_in_item;

    typedef struct packed {
        logic [RANK_W-1:0]  place_rank;
        logic [TAG_W-1:0]   entry_tag;
        logic [VALUE_W-1:0] entry_value;
        logic               last_entry;
    } t_out_item;

endpackage

// ===== hdl/tkt_ram.sv =====
module tkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one read port with registered read data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/top_k_tracker.sv =====
// Top-K tracker: keeps ENTRIES (tag, value) slots, all zero after reset. An offer scans the
// slot memory once through one comparator to find the first smallest value and replaces that
// slot when the offered value is non-negative and strictly greater; it holds the input off
// until the scan and the write are done. A report emits every slot ordered by value
// descending, then tag ascending, with competition ranks. Each result costs one full scan
// of the memory plus the output transfer, which can stall. A clear only resets the slots
// and needs no scan. The single read port of the slot memory is why each result needs its
// own full scan. The input is ready only while idle.
module top_k_tracker #(
    parameter int ENTRIES = tkt_pkg::DEF_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tkt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tkt_pkg::t_out_item o_out_data
);
    import tkt_pkg::*;

    localparam int IW    = $clog2(ENTRIES);
    localparam int CW    = $clog2(ENTRIES + 1);
    localparam int KEY_W = VALUE_W + TAG_W + IW;
    localparam int MEM_W = VALUE_W + TAG_W;

    localparam logic [CW-1:0] CNT_LAST = CW'(ENTRIES);
    localparam logic [IW-1:0] POS_LAST = IW'(ENTRIES - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_EMIT
    } t_state;

    t_state             r_state;
    t_in_item           r_item;
    logic               r_report;
    logic [CW-1:0]      r_cnt;
    logic [IW-1:0]      r_rd_idx;
    logic               r_rd_bit;
    logic [ENTRIES-1:0] r_valid;
    logic [VALUE_W-1:0] r_best_val;
    logic [IW-1:0]      r_best_idx;
    logic [KEY_W-1:0]   r_best_key;
    logic               r_have;
    logic [KEY_W-1:0]   r_prev_key;
    logic [IW-1:0]      r_pos;
    t_out_item          r_out;

    logic [VALUE_W-1:0] n_best_val;
    logic [IW-1:0]      n_best_idx;
    logic [KEY_W-1:0]   n_best_key;
    logic               n_have;

    logic [IW-1:0]      rd_addr;
    logic [MEM_W-1:0]   ram_q;
    logic               ram_we;
    logic [VALUE_W-1:0] d_val;
    logic [KEY_W-1:0]   d_key;
    logic               d_eligible;
    logic               replace;
    logic [VALUE_W-1:0] best_key_val;

    // Slot memory: value in the upper bits, tag in the lower bits.
    tkt_ram #(
        .WIDTH (MEM_W),
        .DEPTH (ENTRIES)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_best_idx),
        .i_wdata ({r_item.candidate_value[VALUE_W-1:0], r_item.candidate_tag}),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // Read address runs over the slots; the last scan cycle only drains read data.
    assign rd_addr = (r_cnt < CNT_LAST) ? r_cnt[IW-1:0] : '0;

    // A slot that was never written since reset or clear reads as zero.
    assign d_val = r_rd_bit ? ram_q[MEM_W-1:TAG_W] : '0;

    // Sort key: larger key reports first. Index breaks ties between identical pairs.
    assign d_key = {d_val, ~(r_rd_bit ? ram_q[TAG_W-1:0] : {TAG_W{1'b0}}), ~r_rd_idx};
    assign d_eligible = (r_pos == '0) || (d_key < r_prev_key);

    // Offer replaces the minimum when the candidate is non-negative and strictly greater.
    assign replace = !r_item.candidate_value[CAND_W-1]
                     && (r_item.candidate_value[VALUE_W-1:0] > r_best_val);
    assign ram_we  = (r_state == S_WRITE) && replace;

    // Shared comparator: running minimum for offers, next key below the last one for reports.
    always_comb begin
        n_best_val = r_best_val;
        n_best_idx = r_best_idx;
        n_best_key = r_best_key;
        n_have     = r_have;
        if (r_state == S_SCAN && r_cnt != '0) begin
            if (r_report) begin
                if (d_eligible && (!r_have || d_key > r_best_key)) begin
                    n_best_key = d_key;
                    n_have     = 1'b1;
                end
            end else if (r_cnt == CW'(1) || d_val < r_best_val) begin
                n_best_val = d_val;
                n_best_idx = r_rd_idx;
            end
        end
    end

    assign best_key_val = n_best_key[KEY_W-1 -: VALUE_W];

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_cnt    <= '0;
            r_have   <= 1'b0;
            r_pos    <= '0;
            r_report <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item <= i_in_data;
                        r_cnt  <= '0;
                        r_pos  <= '0;
                        r_have <= 1'b0;
                        case (i_in_data.func)
                            FUNC_OFFER: begin
                                r_report <= 1'b0;
                                r_state  <= S_SCAN;
                            end
                            FUNC_REPORT: begin
                                r_report <= 1'b1;
                                r_state  <= S_SCAN;
                            end
                            FUNC_CLEAR: begin
                                r_valid <= '0;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    r_rd_bit   <= r_valid[rd_addr];
                    r_rd_idx   <= rd_addr;
                    r_best_val <= n_best_val;
                    r_best_idx <= n_best_idx;
                    r_best_key <= n_best_key;
                    r_have     <= n_have;
                    if (r_cnt == CNT_LAST) begin
                        r_cnt <= '0;
                        if (r_report) begin
                            if (r_pos == '0
                                || best_key_val != r_prev_key[KEY_W-1 -: VALUE_W]) begin
                                r_out.place_rank <= RANK_W'(r_pos) + RANK_W'(1);
                            end
                            r_out.entry_tag   <= ~n_best_key[IW +: TAG_W];
                            r_out.entry_value <= best_key_val;
                            r_out.last_entry  <= (r_pos == POS_LAST);
                            r_state           <= S_EMIT;
                        end else begin
                            r_state <= S_WRITE;
                        end
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_WRITE: begin
                    if (replace) begin
                        r_valid[r_best_idx] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_prev_key <= r_best_key;
                        r_have     <= 1'b0;
                        if (r_pos == POS_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_pos   <= r_pos + IW'(1);
                            r_state <= S_SCAN;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_data  = r_out;

endmodule

// ===== sim/top_k_tracker_checker.sv =====
// Watches both channels of the top-K tracker, keeps its own copy of the slot table, and
// compares every output transfer against the oldest predicted ranking entry.
module top_k_tracker_checker #(
    parameter int ENTRIES = tkt_pkg::DEF_ENTRIES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  tkt_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  tkt_pkg::t_out_item i_out_data,
    output int                 o_fail_count,
    output int                 o_pending
);
    import tkt_pkg::*;

    // Keep the log readable when the block is badly broken.
    localparam int MAX_PRINTS = 200;

    logic [VALUE_W-1:0] tbl_value [ENTRIES];
    logic [TAG_W-1:0]   tbl_tag   [ENTRIES];
    t_out_item          ranking_q [$];
    int                 fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic log_fail(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTS) begin
            $display("%s", msg);
        end
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            log_fail($sformatf("%0t: %s expected %0d actual %0d", $time, name, want, got));
        end
    endtask

    // An offer replaces the first smallest slot when the candidate is strictly greater.
    task automatic apply_offer(input logic [TAG_W-1:0] tag,
                               input logic signed [CAND_W-1:0] value);
        int low_idx;
        low_idx = 0;
        for (int i = 1; i < ENTRIES; i++) begin
            if (tbl_value[i] < tbl_value[low_idx]) begin
                low_idx = i;
            end
        end
        if ($signed({1'b0, tbl_value[low_idx]}) < value) begin
            tbl_value[low_idx] = value[VALUE_W-1:0];
            tbl_tag[low_idx]   = tag;
        end
    endtask

    // A report sorts a copy of the table by value descending, then tag ascending,
    // and queues one entry per slot with its competition rank.
    task automatic push_ranking();
        logic [VALUE_W-1:0] vals [ENTRIES];
        logic [TAG_W-1:0]   tags [ENTRIES];
        logic [VALUE_W-1:0] v;
        logic [TAG_W-1:0]   t;
        int                 j;
        int                 rank;
        t_out_item          entry;
        vals = tbl_value;
        tags = tbl_tag;
        for (int i = 1; i < ENTRIES; i++) begin
            v = vals[i];
            t = tags[i];
            j = i;
            while (j > 0 && (v > vals[j-1] || (v == vals[j-1] && t < tags[j-1]))) begin
                vals[j] = vals[j-1];
                tags[j] = tags[j-1];
                j--;
            end
            vals[j] = v;
            tags[j] = t;
        end
        rank = 1;
        for (int i = 0; i < ENTRIES; i++) begin
            if (i > 0 && vals[i] != vals[i-1]) begin
                rank = i + 1;
            end
            entry.place_rank  = RANK_W'(rank);
            entry.entry_tag   = tags[i];
            entry.entry_value = vals[i];
            entry.last_entry  = (i == ENTRIES - 1);
            ranking_q.push_back(entry);
        end
    endtask

    // Output transfers are checked before the input transfer of the same edge is predicted.
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                tbl_value[i] = '0;
                tbl_tag[i]   = '0;
            end
            ranking_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (ranking_q.size() == 0) begin
                    log_fail($sformatf("%0t: result expected none, actual tag %0d value %0d",
                                       $time, i_out_data.entry_tag, i_out_data.entry_value));
                end else begin
                    want = ranking_q.pop_front();
                    check_field("place_rank", want.place_rank, i_out_data.place_rank);
                    check_field("entry_tag", want.entry_tag, i_out_data.entry_tag);
                    check_field("entry_value", want.entry_value, i_out_data.entry_value);
                    check_field("last_entry", want.last_entry, i_out_data.last_entry);
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_in_data.func)
                    FUNC_OFFER: begin
                        apply_offer(i_in_data.candidate_tag, i_in_data.candidate_value);
                    end
                    FUNC_REPORT: begin
                        push_ranking();
                    end
                    FUNC_CLEAR: begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            tbl_value[i] = '0;
                            tbl_tag[i]   = '0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending <= ranking_q.size();
    end

endmodule

// ===== sim/tb_top_k_tracker.sv =====
// Stimulus and verdict for the top-K tracker; the checker does all prediction.
module tb_top_k_tracker;
    import tkt_pkg::*;

    localparam int ENTRIES       = DEF_ENTRIES;
    localparam int N_ITEMS       = 460;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 4 * (ENTRIES + 2);
    localparam longint LIMIT     = 4 * (longint'(N_ITEMS) * (ENTRIES * (ENTRIES + 26) +
                                   ENTRIES + 40) + HOLD_CYCLES + 20000);

    // The one function code that the block ignores.
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_data   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_data;
    int        fails;
    int        pending;

    // calm and hold_go are shared between the sender and receiver processes; the rest belong to one of them.
    logic      calm      = 1'b0;
    logic      hold_go   = 1'b0;
    logic      hold_done = 1'b0;
    int        hold_left = 0;
    int        n_counted = 0;

    always #2 clk = ~clk;

    top_k_tracker #(.ENTRIES(ENTRIES)) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    top_k_tracker_checker #(.ENTRIES(ENTRIES)) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    function automatic t_in_item make_item(input logic [FUNC_W-1:0] func,
                                           input logic [TAG_W-1:0] tag,
                                           input logic [CAND_W-1:0] value);
        t_in_item it;
        it.func            = func;
        it.candidate_tag   = tag;
        it.candidate_value = value;
        return it;
    endfunction

    // Mostly offers, with small values and tags often enough to force ties.
    function automatic t_in_item rand_item();
        t_in_item it;
        int       pick;
        pick = $urandom_range(999);
        if (pick < 100) begin
            it.func = FUNC_REPORT;
        end else if (pick < 115) begin
            it.func = FUNC_CLEAR;
        end else if (pick < 145) begin
            it.func = FUNC_UNUSED;
        end else begin
            it.func = FUNC_OFFER;
        end
        it.candidate_tag = ($urandom_range(2) == 0) ? $urandom_range(3) : $urandom;
        case ($urandom_range(9))
            0, 1, 2: it.candidate_value = $urandom_range(7);
            3, 4, 5: it.candidate_value = $urandom;
            6:       it.candidate_value = {1'b1, 31'($urandom)};
            7: begin
                case ($urandom_range(5))
                    0:       it.candidate_value = 32'h0000_0000;
                    1:       it.candidate_value = 32'h0000_0001;
                    2:       it.candidate_value = 32'h7FFF_FFFF;
                    3:       it.candidate_value = 32'h7FFF_FFFE;
                    4:       it.candidate_value = 32'h8000_0000;
                    default: it.candidate_value = 32'hFFFF_FFFF;
                endcase
            end
            default: it.candidate_value = {1'b0, 31'($urandom)};
        endcase
        return it;
    endfunction

    // One input transfer, optionally preceded by a random idle gap.
    task automatic send(input t_in_item it);
        if (!calm && $urandom_range(99) < 22) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 22);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        if (it.func != FUNC_UNUSED) begin
            n_counted++;
        end
    endtask

    // Stop offering until every predicted entry has arrived and the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0 || !in_ready);
    endtask

    // Receiver: random stalls, one long hold-off, and no stalls during the calm stretch.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end else if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end else begin
            out_ready <= calm || ($urandom_range(99) >= 22);
        end
    end

    // Watchdog on total run length.
    initial begin
        longint cycle_count;
        cycle_count = 0;
        while (cycle_count < LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[top_k_tracker] ERROR");
        $finish;
    end

    initial begin
        t_in_item it;
        logic     paused;
        paused = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, dropped offers, extremes, ties, unused code, clear.
        send(make_item(FUNC_REPORT, 32'd0, 32'd0));
        send(make_item(FUNC_OFFER, 32'd5, 32'd0));
        send(make_item(FUNC_OFFER, 32'd6, 32'hFFFF_FFFF));
        send(make_item(FUNC_OFFER, 32'd7, 32'h8000_0000));
        send(make_item(FUNC_OFFER, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
        send(make_item(FUNC_OFFER, 32'd0, 32'd1));
        send(make_item(FUNC_OFFER, 32'd3, 32'd100));
        send(make_item(FUNC_OFFER, 32'd1, 32'd100));
        send(make_item(FUNC_OFFER, 32'd2, 32'd100));
        send(make_item(FUNC_OFFER, 32'hAAAA_AAAA, 32'h5555_5555));
        send(make_item(FUNC_UNUSED, 32'h5555_5555, 32'h7FFF_FFFF));
        send(make_item(FUNC_REPORT, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(make_item(FUNC_CLEAR, 32'd0, 32'd0));
        send(make_item(FUNC_REPORT, 32'd0, 32'd0));
        send(make_item(FUNC_OFFER, 32'd9, 32'd50));
        send(make_item(FUNC_OFFER, 32'd9, 32'd50));
        send(make_item(FUNC_OFFER, 32'd4, 32'h7FFF_FFFF));
        send(make_item(FUNC_OFFER, 32'd8, 32'd50));
        send(make_item(FUNC_REPORT, 32'd0, 32'd0));
        drain();

        // Random part with one calm stretch, one long output hold-off and one full pause.
        while (n_counted < N_ITEMS) begin
            it = rand_item();
            if (it.func == FUNC_REPORT && !hold_go) begin
                hold_go <= 1'b1;
            end
            calm <= (n_counted >= 200 && n_counted < 280);
            send(it);
            if (!paused && n_counted >= 320) begin
                paused = 1'b1;
                drain();
            end
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fails == 0) begin
            $display("[top_k_tracker] OK");
        end else begin
            $display("[top_k_tracker] ERROR");
        end
        $finish;
    end

endmodule
